FILE: design/bnlj_pkg.sv
// Shared types and codes for the block nested loop join engine.
// Depends on nothing; the controller, datapath, top and testbench refer to it by scoped names.
package bnlj_pkg;

    // Field widths fixed by the item format
    localparam int KEY_W = 31;
    localparam int REF_W = 32;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_PROBE = 2'd1,
        CMD_CLEAR = 2'd2
    } t_command;

    typedef enum logic [1:0] {
        RES_JOINED     = 2'd0,
        RES_NO_MATCH   = 2'd1,
        RES_BLOCK_FULL = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COMPARE,
        ST_FETCH,
        ST_LOAD_OUT,
        ST_POST_FULL,
        ST_POST_NONE
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;     // latch probe fields of the accepted item
        logic load_write;  // store key and name ref in the next free slot
        logic clear;       // empty the block
        logic compare;     // build the match vector
        logic fetch;       // read name ref of the lowest match, retire it
        logic out_row;     // load the output register with a joined row
        logic out_full;    // load the output register with a block full result
        logic out_none;    // load the output register with a no match result
    } t_dp_ctrl;

    // Status from the datapath to the controller
    typedef struct packed {
        logic [1:0] in_command;
        logic       has_room;
        logic       match_none;
        logic       fetch_last;
        logic       out_free;
    } t_dp_stat;

endpackage

FILE: design/bnlj_ram.sv
// Generic single write port, single read port RAM with registered read data.
// Stand-alone; no package needed.
module bnlj_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                      i_wr_data,
    input  logic                                  i_rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                      o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        // Hold read data until the next read
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: design/bnlj_datapath.sv
// Datapath of the join engine: key registers, match vector, fill count,
// name reference memory and output register. Uses bnlj_pkg and bnlj_ram.
module bnlj_datapath #(
    parameter int BLOCK_DEPTH = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  bnlj_pkg::t_dp_ctrl               i_ctrl,
    output bnlj_pkg::t_dp_stat               o_stat,
    input  logic [1:0]                       i_command,
    input  logic [bnlj_pkg::KEY_W-1:0]       i_join_key,
    input  logic [bnlj_pkg::REF_W-1:0]       i_customer_ref,
    input  logic [bnlj_pkg::KEY_W-1:0]       i_order_key,
    input  logic [bnlj_pkg::REF_W-1:0]       i_comment_ref,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    output logic [1:0]                       o_status,
    output logic [bnlj_pkg::KEY_W-1:0]       o_customer_key,
    output logic [bnlj_pkg::REF_W-1:0]       o_name_ref,
    output logic [bnlj_pkg::KEY_W-1:0]       o_joined_order_key,
    output logic [bnlj_pkg::REF_W-1:0]       o_joined_comment_ref,
    output logic                             o_last
);

    localparam int IDX_W = (BLOCK_DEPTH > 1) ? $clog2(BLOCK_DEPTH) : 1;
    localparam int CNT_W = $clog2(BLOCK_DEPTH + 1);

    logic [CNT_W-1:0]             r_fill;
    logic [bnlj_pkg::KEY_W-1:0]   r_key [BLOCK_DEPTH];
    logic [BLOCK_DEPTH-1:0]       r_match;
    logic [BLOCK_DEPTH-1:0]       n_match;
    logic [BLOCK_DEPTH-1:0]       low_bit;
    logic [BLOCK_DEPTH-1:0]       rest_match;
    logic [IDX_W-1:0]             low_idx;
    logic                         r_fetch_last;

    logic [bnlj_pkg::KEY_W-1:0]   r_join_key;
    logic [bnlj_pkg::KEY_W-1:0]   r_order_key;
    logic [bnlj_pkg::REF_W-1:0]   r_comment_ref;
    logic [bnlj_pkg::REF_W-1:0]   name_rd_data;

    logic                         r_out_valid;
    logic [1:0]                   r_out_status;
    logic [bnlj_pkg::KEY_W-1:0]   r_out_customer_key;
    logic [bnlj_pkg::REF_W-1:0]   r_out_name_ref;
    logic [bnlj_pkg::KEY_W-1:0]   r_out_order_key;
    logic [bnlj_pkg::REF_W-1:0]   r_out_comment_ref;
    logic                         r_out_last;
    logic                         out_load;

    bnlj_ram #(
        .WIDTH (bnlj_pkg::REF_W),
        .DEPTH (BLOCK_DEPTH)
    ) u_name_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_ctrl.load_write),
        .i_wr_addr (r_fill[IDX_W-1:0]),
        .i_wr_data (i_customer_ref),
        .i_rd_en   (i_ctrl.fetch),
        .i_rd_addr (low_idx),
        .o_rd_data (name_rd_data)
    );

    // Compare every occupied slot against the probe key
    always_comb begin
        for (int i = 0; i < BLOCK_DEPTH; i++) begin
            n_match[i] = (CNT_W'(i) < r_fill) && (r_key[i] == r_join_key);
        end
    end

    // Isolate the lowest pending match and encode its slot number
    assign low_bit    = r_match & (~r_match + BLOCK_DEPTH'(1));
    assign rest_match = r_match & ~low_bit;

    always_comb begin
        low_idx = '0;
        for (int i = 0; i < BLOCK_DEPTH; i++) begin
            if (low_bit[i]) begin
                low_idx = low_idx | IDX_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_ctrl.clear) begin
            r_fill <= '0;
        end else if (i_ctrl.load_write) begin
            r_fill <= r_fill + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_write) begin
            r_key[r_fill[IDX_W-1:0]] <= i_join_key;
        end
        if (i_ctrl.capture) begin
            r_join_key    <= i_join_key;
            r_order_key   <= i_order_key;
            r_comment_ref <= i_comment_ref;
        end
        if (i_ctrl.compare) begin
            r_match <= n_match;
        end else if (i_ctrl.fetch) begin
            r_match      <= rest_match;
            r_fetch_last <= (rest_match == '0);
        end
    end

    // Output register
    assign out_load = i_ctrl.out_row | i_ctrl.out_full | i_ctrl.out_none;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.out_row) begin
            r_out_status       <= bnlj_pkg::RES_JOINED;
            r_out_customer_key <= r_join_key;
            r_out_name_ref     <= name_rd_data;
            r_out_order_key    <= r_order_key;
            r_out_comment_ref  <= r_comment_ref;
            r_out_last         <= r_fetch_last;
        end else if (i_ctrl.out_none) begin
            r_out_status       <= bnlj_pkg::RES_NO_MATCH;
            r_out_customer_key <= '0;
            r_out_name_ref     <= '0;
            r_out_order_key    <= r_order_key;
            r_out_comment_ref  <= r_comment_ref;
            r_out_last         <= 1'b1;
        end else if (i_ctrl.out_full) begin
            r_out_status       <= bnlj_pkg::RES_BLOCK_FULL;
            r_out_customer_key <= '0;
            r_out_name_ref     <= '0;
            r_out_order_key    <= '0;
            r_out_comment_ref  <= '0;
            r_out_last         <= 1'b1;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_status             = r_out_status;
    assign o_customer_key       = r_out_customer_key;
    assign o_name_ref           = r_out_name_ref;
    assign o_joined_order_key   = r_out_order_key;
    assign o_joined_comment_ref = r_out_comment_ref;
    assign o_last               = r_out_last;

    assign o_stat.in_command = i_command;
    assign o_stat.has_room   = (r_fill < CNT_W'(BLOCK_DEPTH));
    assign o_stat.match_none = (r_match == '0);
    assign o_stat.fetch_last = r_fetch_last;
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

endmodule

FILE: design/bnlj_ctrl.sv
// Controller state machine of the join engine.
// Uses bnlj_pkg for its state type and the command and status structs.
module bnlj_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  bnlj_pkg::t_dp_stat i_stat,
    output bnlj_pkg::t_dp_ctrl o_ctrl
);

    bnlj_pkg::t_state r_state;
    bnlj_pkg::t_state n_state;
    logic             accept;

    assign accept = (r_state == bnlj_pkg::ST_IDLE) && i_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bnlj_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bnlj_pkg::ST_IDLE: begin
                if (accept) begin
                    unique case (i_stat.in_command)
                        bnlj_pkg::CMD_LOAD: begin
                            if (!i_stat.has_room) begin
                                n_state = bnlj_pkg::ST_POST_FULL;
                            end
                        end
                        bnlj_pkg::CMD_PROBE: n_state = bnlj_pkg::ST_COMPARE;
                        default:             n_state = bnlj_pkg::ST_IDLE;
                    endcase
                end
            end
            bnlj_pkg::ST_COMPARE: n_state = bnlj_pkg::ST_FETCH;
            bnlj_pkg::ST_FETCH: begin
                n_state = i_stat.match_none ? bnlj_pkg::ST_POST_NONE : bnlj_pkg::ST_LOAD_OUT;
            end
            bnlj_pkg::ST_LOAD_OUT: begin
                if (i_stat.out_free) begin
                    n_state = i_stat.fetch_last ? bnlj_pkg::ST_IDLE : bnlj_pkg::ST_FETCH;
                end
            end
            bnlj_pkg::ST_POST_FULL, bnlj_pkg::ST_POST_NONE: begin
                if (i_stat.out_free) begin
                    n_state = bnlj_pkg::ST_IDLE;
                end
            end
            default: n_state = bnlj_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_ready           = (r_state == bnlj_pkg::ST_IDLE);
        o_ctrl            = '0;
        o_ctrl.capture    = accept;
        o_ctrl.load_write = accept && (i_stat.in_command == bnlj_pkg::CMD_LOAD)
                            && i_stat.has_room;
        o_ctrl.clear      = accept && (i_stat.in_command == bnlj_pkg::CMD_CLEAR);
        o_ctrl.compare    = (r_state == bnlj_pkg::ST_COMPARE);
        o_ctrl.fetch      = (r_state == bnlj_pkg::ST_FETCH) && !i_stat.match_none;
        o_ctrl.out_row    = (r_state == bnlj_pkg::ST_LOAD_OUT) && i_stat.out_free;
        o_ctrl.out_full   = (r_state == bnlj_pkg::ST_POST_FULL) && i_stat.out_free;
        o_ctrl.out_none   = (r_state == bnlj_pkg::ST_POST_NONE) && i_stat.out_free;
    end

endmodule

FILE: design/block_nested_loop_join_top.sv
// Block nested loop join engine for one block of the outer table.
// Input channel (i_valid/o_ready) carries load, probe and clear items;
// output channel (o_valid/i_ready) carries result items, one per cycle at most.
// Load: stored in the next free slot, no result; on a full block the load is
//   dropped and one block full result follows, loaded into the output
//   register from the POST_FULL state.
// Clear and the unused command code: no result.
// Probe: compare all stored keys into a match vector, then for each match
//   read the name reference memory and load the output register. The single
//   read port of the name memory and the fetch/load step of the controller
//   handle one match at a time; a probe with no match posts one no match
//   result. The input is held until the last result of the probe is loaded.
// Rows come out in load order and the final one carries o_last.
// Reset empties the block and the output register; stored keys and names
//   are not cleared, as only occupied slots are ever compared or read.
// A stall on the output holds the result in the output register and the
//   controller waits; new items are taken only between items.
// Depends on bnlj_pkg, bnlj_ctrl, bnlj_datapath and bnlj_ram.
module block_nested_loop_join_top #(
    parameter int BLOCK_DEPTH = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [1:0]                 i_command,
    input  logic [bnlj_pkg::KEY_W-1:0] i_join_key,
    input  logic [bnlj_pkg::REF_W-1:0] i_customer_ref,
    input  logic [bnlj_pkg::KEY_W-1:0] i_order_key,
    input  logic [bnlj_pkg::REF_W-1:0] i_comment_ref,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [1:0]                 o_status,
    output logic [bnlj_pkg::KEY_W-1:0] o_customer_key,
    output logic [bnlj_pkg::REF_W-1:0] o_name_ref,
    output logic [bnlj_pkg::KEY_W-1:0] o_joined_order_key,
    output logic [bnlj_pkg::REF_W-1:0] o_joined_comment_ref,
    output logic                       o_last
);

    bnlj_pkg::t_dp_ctrl dp_ctrl;
    bnlj_pkg::t_dp_stat dp_stat;

    // Sequence each item: accept, compare, fetch matches, post results
    bnlj_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (dp_stat),
        .o_ctrl  (dp_ctrl)
    );

    // Hold the block, build matches and drive the output register
    bnlj_datapath #(
        .BLOCK_DEPTH (BLOCK_DEPTH)
    ) u_datapath (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_ctrl               (dp_ctrl),
        .o_stat               (dp_stat),
        .i_command            (i_command),
        .i_join_key           (i_join_key),
        .i_customer_ref       (i_customer_ref),
        .i_order_key          (i_order_key),
        .i_comment_ref        (i_comment_ref),
        .i_out_ready          (i_ready),
        .o_out_valid          (o_valid),
        .o_status             (o_status),
        .o_customer_key       (o_customer_key),
        .o_name_ref           (o_name_ref),
        .o_joined_order_key   (o_joined_order_key),
        .o_joined_comment_ref (o_joined_comment_ref),
        .o_last               (o_last)
    );

endmodule

FILE: tb/sv/block_nested_loop_join_top_test.sv
// Self-checking testbench for block_nested_loop_join_top: a directed script, then random
// clear/load/probe phases, with results checked against a predictor of the join block.
// Depends on bnlj_pkg and the block's RTL only.
module block_nested_loop_join_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int KEY_W = bnlj_pkg::KEY_W;
    localparam int REF_W = bnlj_pkg::REF_W;

    localparam int BLOCK_DEPTH  = 64;
    localparam int RANDOM_ITEMS = 200;
    // Slowest legal run: every item a full probe with long output stalls, then several times that
    localparam int CYCLE_LIMIT  = 2_000_000;
    // Wait past the longest probe at the end, so that stray results are still caught
    localparam int TAIL_CYCLES  = 2 * BLOCK_DEPTH + 20;

    localparam logic [1:0]       CMD_UNUSED = 2'd3;
    localparam logic [KEY_W-1:0] MAX_KEY    = 31'h7FFF_FFFF;
    localparam logic [REF_W-1:0] MAX_REF    = 32'hFFFF_FFFF;

    // One result item as it leaves the block
    typedef struct packed {
        bnlj_pkg::t_status status;
        logic [KEY_W-1:0]  customer_key;
        logic [REF_W-1:0]  name_ref;
        logic [KEY_W-1:0]  order_key;
        logic [REF_W-1:0]  comment_ref;
        logic              last;
    } t_join_row;

    // How a script row is checked: by the predictor, or against a result typed in the row
    typedef enum logic [1:0] {
        BY_MODEL,
        WANT_NONE,
        WANT_ONE
    } t_check_kind;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [KEY_W-1:0] jk;
        logic [REF_W-1:0] cref;
        logic [KEY_W-1:0] ok;
        logic [REF_W-1:0] comref;
        int               reps;      // repeat the row, customer ref counting up
        t_check_kind      kind;
        t_join_row        want;
    } t_stim_row;

    localparam t_join_row NO_ROW = '0;

    // Directed script: extremes, every command, the unused code, a full block and its overflow
    localparam t_stim_row SCRIPT [19] = '{
        // Probe right after reset: the block is empty, so no match
        '{bnlj_pkg::CMD_PROBE, 31'd0, 32'd0, MAX_KEY, MAX_REF, 1, WANT_ONE,
          '{bnlj_pkg::RES_NO_MATCH, 31'd0, 32'd0, MAX_KEY, MAX_REF, 1'b1}},
        // Unused code with every bit set: ignored, nothing stored
        '{CMD_UNUSED, MAX_KEY, MAX_REF, MAX_KEY, MAX_REF, 1, WANT_NONE, NO_ROW},
        '{bnlj_pkg::CMD_PROBE, MAX_KEY, MAX_REF, 31'd0, 32'd0, 1, WANT_ONE,
          '{bnlj_pkg::RES_NO_MATCH, 31'd0, 32'd0, 31'd0, 32'd0, 1'b1}},
        '{bnlj_pkg::CMD_LOAD, MAX_KEY, MAX_REF, 31'd0, 32'd0, 1, WANT_NONE, NO_ROW},
        '{bnlj_pkg::CMD_LOAD, 31'd0, 32'd0, MAX_KEY, MAX_REF, 1, WANT_NONE, NO_ROW},
        '{bnlj_pkg::CMD_LOAD, MAX_KEY, 32'h1234_5678, 31'd0, 32'd0, 1, WANT_NONE, NO_ROW},
        // Two matches in load order
        '{bnlj_pkg::CMD_PROBE, MAX_KEY, 32'd0, 31'h1555_5555, 32'hAAAA_AAAA, 1, BY_MODEL,
          NO_ROW},
        '{bnlj_pkg::CMD_PROBE, 31'd0, MAX_REF, 31'h2AAA_AAAA, 32'h5555_5555, 1, WANT_ONE,
          '{bnlj_pkg::RES_JOINED, 31'd0, 32'd0, 31'h2AAA_AAAA, 32'h5555_5555, 1'b1}},
        '{bnlj_pkg::CMD_PROBE, 31'd1, 32'd0, 31'd3, 32'd4, 1, BY_MODEL, NO_ROW},
        '{bnlj_pkg::CMD_CLEAR, MAX_KEY, MAX_REF, MAX_KEY, MAX_REF, 1, WANT_NONE, NO_ROW},
        // Probe after clear: stale slots must not match
        '{bnlj_pkg::CMD_PROBE, 31'd0, 32'd0, 31'd7, 32'd9, 1, WANT_ONE,
          '{bnlj_pkg::RES_NO_MATCH, 31'd0, 32'd0, 31'd7, 32'd9, 1'b1}},
        // Fill the whole block with one key
        '{bnlj_pkg::CMD_LOAD, 31'h2AAA_AAAA, 32'h8000_0000, 31'd0, 32'd0, BLOCK_DEPTH,
          WANT_NONE, NO_ROW},
        // Load into a full block: dropped, block full result with zero fields
        '{bnlj_pkg::CMD_LOAD, 31'd5, 32'd6, 31'd7, 32'd8, 1, WANT_ONE,
          '{bnlj_pkg::RES_BLOCK_FULL, 31'd0, 32'd0, 31'd0, 32'd0, 1'b1}},
        '{CMD_UNUSED, 31'd0, 32'd0, 31'd0, 32'd0, 1, WANT_NONE, NO_ROW},
        // Every slot matches: the longest burst of rows
        '{bnlj_pkg::CMD_PROBE, 31'h2AAA_AAAA, 32'd0, MAX_KEY, 32'd0, 1, BY_MODEL, NO_ROW},
        '{bnlj_pkg::CMD_PROBE, 31'd5, 32'd0, 31'd1, 32'd2, 1, BY_MODEL, NO_ROW},
        '{bnlj_pkg::CMD_CLEAR, 31'd0, 32'd0, 31'd0, 32'd0, 1, WANT_NONE, NO_ROW},
        '{bnlj_pkg::CMD_LOAD, 31'd3, 32'd11, 31'd0, 32'd0, 1, BY_MODEL, NO_ROW},
        '{bnlj_pkg::CMD_PROBE, 31'd3, 32'd0, 31'd12, 32'd13, 1, BY_MODEL, NO_ROW}
    };

    logic             i_clk;
    logic             i_rst_n;
    logic             i_valid;
    logic             o_ready;
    logic [1:0]       i_command;
    logic [KEY_W-1:0] i_join_key;
    logic [REF_W-1:0] i_customer_ref;
    logic [KEY_W-1:0] i_order_key;
    logic [REF_W-1:0] i_comment_ref;
    logic             o_valid;
    logic             i_ready;
    logic [1:0]       o_status;
    logic [KEY_W-1:0] o_customer_key;
    logic [REF_W-1:0] o_name_ref;
    logic [KEY_W-1:0] o_joined_order_key;
    logic [REF_W-1:0] o_joined_comment_ref;
    logic             o_last;

    // Predictor's copy of the block contents
    logic [KEY_W-1:0] cust_keys  [BLOCK_DEPTH];
    logic [REF_W-1:0] cust_names [BLOCK_DEPTH];
    int unsigned      cust_count = 0;

    t_join_row model_rows[$];    // rows caused by the item just accepted
    t_join_row pending_rows[$];  // rows still owed by the block, oldest first
    t_join_row got_row;
    t_join_row want_row;

    int  mismatches   = 0;
    int  random_count = 0;
    int  cycle_count  = 0;
    bit  calm         = 1'b0;    // when set, neither side idles

    logic [KEY_W-1:0] key_pool [8];
    int               pool_size = 1;

    block_nested_loop_join_top #(
        .BLOCK_DEPTH(BLOCK_DEPTH)
    ) DUT (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_command           (i_command),
        .i_join_key          (i_join_key),
        .i_customer_ref      (i_customer_ref),
        .i_order_key         (i_order_key),
        .i_comment_ref       (i_comment_ref),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_status            (o_status),
        .o_customer_key      (o_customer_key),
        .o_name_ref          (o_name_ref),
        .o_joined_order_key  (o_joined_order_key),
        .o_joined_comment_ref(o_joined_comment_ref),
        .o_last              (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Gap length for either side: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    // Keys with extremes mixed in, so both ends of the key range get stored and probed
    function automatic logic [KEY_W-1:0] rand_key();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return MAX_KEY;
        return KEY_W'($urandom());
    endfunction

    // Advance the predicted block by one item and collect the rows it causes
    function automatic void join_model(input logic [1:0] cmd, input logic [KEY_W-1:0] jk,
                                       input logic [REF_W-1:0] cref,
                                       input logic [KEY_W-1:0] ok,
                                       input logic [REF_W-1:0] comref);
        t_join_row row;
        model_rows.delete();
        case (cmd)
            bnlj_pkg::CMD_LOAD: begin
                if (cust_count >= BLOCK_DEPTH) begin
                    row = '{bnlj_pkg::RES_BLOCK_FULL, '0, '0, '0, '0, 1'b1};
                    model_rows.insert(model_rows.size(), row);
                end else begin
                    cust_keys[cust_count]  = jk;
                    cust_names[cust_count] = cref;
                    cust_count++;
                end
            end
            bnlj_pkg::CMD_PROBE: begin
                for (int i = 0; i < cust_count; i++) begin
                    if (cust_keys[i] == jk) begin
                        row = '{bnlj_pkg::RES_JOINED, cust_keys[i], cust_names[i],
                                ok, comref, 1'b0};
                        model_rows.insert(model_rows.size(), row);
                    end
                end
                if (model_rows.size() == 0) begin
                    row = '{bnlj_pkg::RES_NO_MATCH, '0, '0, ok, comref, 1'b1};
                    model_rows.insert(model_rows.size(), row);
                end else begin
                    model_rows[model_rows.size() - 1].last = 1'b1;
                end
            end
            bnlj_pkg::CMD_CLEAR: cust_count = 0;
            default: ;  // unused code: ignore
        endcase
    endfunction

    // Present one item, hold it until accepted, then queue what it owes
    task automatic send_item(input logic [1:0] cmd, input logic [KEY_W-1:0] jk,
                             input logic [REF_W-1:0] cref, input logic [KEY_W-1:0] ok,
                             input logic [REF_W-1:0] comref, input t_check_kind kind,
                             input t_join_row want);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk) i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_command      <= cmd;
        i_join_key     <= jk;
        i_customer_ref <= cref;
        i_order_key    <= ok;
        i_comment_ref  <= comref;
        i_valid        <= 1'b1;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        join_model(cmd, jk, cref, ok, comref);
        case (kind)
            BY_MODEL: pending_rows = {pending_rows, model_rows};
            WANT_ONE: pending_rows.insert(pending_rows.size(), want);
            default: ;
        endcase
    endtask

    // One item of a random phase: mostly the given command on pool keys, some noise
    task automatic send_phase_item(input logic [1:0] cmd);
        logic [1:0]       op;
        logic [KEY_W-1:0] jk;
        op = cmd;
        jk = key_pool[$urandom_range(0, pool_size - 1)];
        if ($urandom_range(0, 9) == 0) begin
            op = 2'($urandom_range(0, 3));
            jk = rand_key();
        end else if ($urandom_range(0, 6) == 0) begin
            jk = rand_key();
        end
        send_item(op, jk, $urandom(), KEY_W'($urandom()), $urandom(), BY_MODEL, NO_ROW);
        if (op != CMD_UNUSED) random_count++;
    endtask

    task automatic report_mismatch(input string what, input t_join_row want,
                                   input t_join_row got);
        if (mismatches < 10)
            $display("%0t %s: want st %0d key %h name %h ord %h com %h last %0d",
                     $realtime, what, want.status, want.customer_key, want.name_ref,
                     want.order_key, want.comment_ref, want.last,
                     "\n    got st %0d key %h name %h ord %h com %h last %0d",
                     got.status, got.customer_key, got.name_ref,
                     got.order_key, got.comment_ref, got.last);
        mismatches++;
    endtask

    // Output stalls: random gaps in i_ready, none while calm
    initial begin
        int hold;
        hold    = 0;
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                hold--;
                i_ready <= 1'b0;
            end else if (calm) begin
                i_ready <= 1'b1;
            end else begin
                hold = pick_gap();
                if (hold > 0) begin
                    hold--;
                    i_ready <= 1'b0;
                end else begin
                    i_ready <= 1'b1;
                end
            end
        end
    end

    // Check every accepted result against the oldest pending row, field by field
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && i_ready === 1'b1) begin
            got_row = '{bnlj_pkg::t_status'(o_status), o_customer_key, o_name_ref,
                        o_joined_order_key, o_joined_comment_ref, o_last};
            if (pending_rows.size() == 0) begin
                report_mismatch("unexpected result", NO_ROW, got_row);
            end else begin
                want_row = pending_rows.pop_front();
                if (got_row.status !== want_row.status
                        || got_row.customer_key !== want_row.customer_key
                        || got_row.name_ref !== want_row.name_ref
                        || got_row.order_key !== want_row.order_key
                        || got_row.comment_ref !== want_row.comment_ref
                        || got_row.last !== want_row.last)
                    report_mismatch("result mismatch", want_row, got_row);
            end
        end
    end

    // Watchdog: end a hung run
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        int n_loads;
        int n_probes;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_command      = bnlj_pkg::CMD_CLEAR;
        i_join_key     = '0;
        i_customer_ref = '0;
        i_order_key    = '0;
        i_comment_ref  = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // Walk the directed script
        foreach (SCRIPT[r]) begin
            for (int k = 0; k < SCRIPT[r].reps; k++)
                send_item(SCRIPT[r].cmd, SCRIPT[r].jk, SCRIPT[r].cref + REF_W'(k),
                          SCRIPT[r].ok, SCRIPT[r].comref, SCRIPT[r].kind, SCRIPT[r].want);
        end

        // Random phases: optional clear, loads on a small key pool, then probes on that pool
        while (random_count < RANDOM_ITEMS) begin
            calm = ($urandom_range(0, 5) == 0);
            if (random_count == 0 || $urandom_range(0, 3) == 0) begin
                // Hold off the sender until the block has paid out everything
                @(negedge i_clk) i_valid <= 1'b0;
                while (pending_rows.size() != 0) @(negedge i_clk);
            end
            pool_size = $urandom_range(1, 6);
            for (int p = 0; p < pool_size; p++) key_pool[p] = rand_key();
            if ($urandom_range(0, 3) != 0) begin
                send_item(bnlj_pkg::CMD_CLEAR, KEY_W'($urandom()), $urandom(),
                          KEY_W'($urandom()), $urandom(), BY_MODEL, NO_ROW);
                random_count++;
            end
            // Now and then load past the block depth to hit the full case
            n_loads  = ($urandom_range(0, 7) == 0) ? $urandom_range(56, 70)
                                                   : $urandom_range(0, 12);
            n_probes = $urandom_range(1, 8);
            repeat (n_loads) send_phase_item(bnlj_pkg::CMD_LOAD);
            repeat (n_probes) send_phase_item(bnlj_pkg::CMD_PROBE);
        end

        // Drain: drop valid, wait for every owed row, then watch for strays
        @(negedge i_clk) i_valid <= 1'b0;
        while (pending_rows.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
